// File: sv/wvrc_pkg.sv
package wvrc_pkg;

	localparam int MAX_SEEDS_DEF  = 16;
	localparam int COORD_BITS_DEF = 24;

	localparam int IDX_W      = 4;
	localparam int WEIGHT_W   = 9;
	localparam int NOISE_W    = 16;
	localparam int REGION_W   = 5;
	localparam int COUNT_W    = 5;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THR  = 1'b1;

	localparam logic [COUNT_W-1:0]         SEED_COUNT_RESET = '0;
	localparam logic signed [NOISE_W-1:0]  NOISE_THR_RESET  = 16'sd6553;

	// Border test |0.5 - d1/(d1+d2)| < 0.15 as 169*s1*w2^2 > 49*s2*w1^2.
	localparam int BORDER_NEAR_K = 169;
	localparam int BORDER_FAR_K  = 49;

	// Controller to datapath.
	typedef struct packed {
		logic               write;
		logic               load_query;
		logic               rd_en;
		logic               rd_first;
		logic               rd_last;
		logic [COUNT_W-1:0] rd_addr;
		logic               border;
		logic               load_out;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic               scan_done;
		logic               out_free;
		logic [COUNT_W-1:0] count;
	} sts_t;

endpackage

// File: sv/weighted_voronoi_region_classifier_core.sv
// Weighted Voronoi region classifier.
//
// Input stream (s_*): s_tuser is the operation. A write transfer (s_tuser 0)
// loads one seed entry with its position and weight and produces no result. A
// query transfer (s_tuser 1) classifies a point and produces exactly one result
// transfer on the output stream (m_*): the chosen region id, and a flag set when
// the point sat near a border, the noise sample was above the threshold and the
// second seed won. Configuration must be written through cfg_we/cfg_index/
// cfg_data only while no query is in work; the block does not enforce this.
//
// A query with n seeds in use reads one seed per cycle from the table into a
// four-stage distance pipeline that updates the running best and second seeds.
// After the last seed leaves the pipeline the border operands are registered,
// then the result is loaded when the output register is free, and the next item
// is taken after that. One item is in work at a time.
//
// Reset clears the controller, the seed count (no seeds) and the threshold
// (6553); the seed table holds no defined contents until written. A stalled
// receiver holds the result in the output register; the block still takes the
// next item and only waits at the end of that query for the register.
module weighted_voronoi_region_classifier_core
	import wvrc_pkg::*;
#(
	parameter int MAX_SEEDS  = MAX_SEEDS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input stream.
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// seed_index, pos_x, pos_z, seed_weight, noise_value (from bit 0 up), zero padded
	input  logic [((2*COORD_BITS+IDX_W+WEIGHT_W+NOISE_W+7)/8)*8-1:0] s_tdata,
	// op
	input  logic                         s_tuser,
	// Output stream.
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// region_id, zero padded
	output logic [7:0]                   m_tdata,
	// border_switched
	output logic                         m_tuser,
	// Configuration write port.
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int C       = COORD_BITS;
	localparam int X_LO    = IDX_W;
	localparam int Z_LO    = X_LO + C;
	localparam int W_LO    = Z_LO + C;
	localparam int N_LO    = W_LO + WEIGHT_W;

	logic [IDX_W-1:0]          seed_index;
	logic signed [C-1:0]       pos_x, pos_z;
	logic [WEIGHT_W-1:0]       seed_weight;
	logic signed [NOISE_W-1:0] noise_value;
	logic [REGION_W-1:0]       region_id;
	logic                      border_switched;

	assign seed_index  = s_tdata[IDX_W-1:0];
	assign pos_x       = $signed(s_tdata[Z_LO-1:X_LO]);
	assign pos_z       = $signed(s_tdata[W_LO-1:Z_LO]);
	assign seed_weight = s_tdata[N_LO-1:W_LO];
	assign noise_value = $signed(s_tdata[N_LO+NOISE_W-1:N_LO]);

	cmd_t cmd;
	sts_t sts;

	// The controller sequences write, scan, border test and result load.
	wvrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (s_tuser),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The datapath holds the table, distance pipeline and output register.
	wvrc_datapath #(
		.MAX_SEEDS  (MAX_SEEDS),
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.seed_index      (seed_index),
		.pos_x           (pos_x),
		.pos_z           (pos_z),
		.seed_weight     (seed_weight),
		.noise_value     (noise_value),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.m_tready        (m_tready),
		.m_tvalid        (m_tvalid),
		.region_id       (region_id),
		.border_switched (border_switched)
	);

	assign m_tdata = {{(8-REGION_W){1'b0}}, region_id};
	assign m_tuser = border_switched;

endmodule

// File: sv/wvrc_ram.sv
module wvrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                    wdata,
	input  logic                                re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                    rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/wvrc_ctrl.sv
module wvrc_ctrl
	import wvrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic op,
	output logic s_tready,
	output cmd_t cmd,
	input  sts_t sts
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_WAIT   = 3'd2;
	localparam logic [2:0] ST_BORDER = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	logic [2:0]         state_q, state_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d;
	logic               accept;
	logic               last_issue;

	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign last_issue = (cnt_q == COUNT_W'(sts.count - COUNT_W'(1)));

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		cmd            = '0;
		cmd.rd_addr    = cnt_q;
		cmd.write      = accept && !op;
		cmd.load_query = accept && op;
		case (state_q)
			ST_IDLE: begin
				if (accept && op) begin
					cnt_d   = '0;
					state_d = (sts.count == '0) ? ST_RESULT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_first = (cnt_q == '0);
				cmd.rd_last  = last_issue;
				cnt_d        = cnt_q + COUNT_W'(1);
				if (last_issue) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (sts.scan_done) begin
					state_d = ST_BORDER;
				end
			end
			ST_BORDER: begin
				cmd.border = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// File: sv/wvrc_datapath.sv
module wvrc_datapath
	import wvrc_pkg::*;
#(
	parameter int MAX_SEEDS  = MAX_SEEDS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output sts_t                         sts,
	input  logic [IDX_W-1:0]             seed_index,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic [WEIGHT_W-1:0]          seed_weight,
	input  logic signed [NOISE_W-1:0]    noise_value,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         m_tready,
	output logic                         m_tvalid,
	output logic [REGION_W-1:0]          region_id,
	output logic                         border_switched
);

	localparam int AW   = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
	localparam int C    = COORD_BITS;
	localparam int EW   = 2 * C + WEIGHT_W;
	localparam int DW   = C + 1;
	localparam int SQW  = 2 * DW;
	localparam int SW   = SQW + 1;
	localparam int W2W  = 2 * WEIGHT_W;
	localparam int PW   = SW + W2W;
	localparam int LW   = PW + 8;

	// Configuration registers.
	logic [COUNT_W-1:0]        count_q;
	logic signed [NOISE_W-1:0] thr_q;
	logic [COUNT_W-1:0]        count_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= SEED_COUNT_RESET;
			thr_q   <= NOISE_THR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEED_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				CFG_NOISE_THR:  thr_q   <= $signed(cfg_data[NOISE_W-1:0]);
				default: ;
			endcase
		end
	end

	assign count_eff = (32'(count_q) > MAX_SEEDS) ? COUNT_W'(MAX_SEEDS) : count_q;

	// Seed table: {weight, z, x} per entry.
	logic          ram_we;
	logic [EW-1:0] ram_rdata;

	assign ram_we = cmd.write && (32'(seed_index) < MAX_SEEDS);

	wvrc_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_SEEDS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(seed_index)),
		.wdata ({seed_weight, pos_z, pos_x}),
		.re    (cmd.rd_en),
		.raddr (AW'(cmd.rd_addr)),
		.rdata (ram_rdata)
	);

	// Query operands, captured when the query is taken.
	logic signed [C-1:0]       qx_q, qz_q;
	logic signed [NOISE_W-1:0] noise_q;
	logic                      empty_q;

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			qx_q    <= pos_x;
			qz_q    <= pos_z;
			noise_q <= noise_value;
			empty_q <= (count_eff == '0);
		end
	end

	// Distance pipeline: s1 table read, s2 differences, s3 squares, s4 sum.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic first_s1, first_s2, first_s3, first_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4;

	logic signed [DW-1:0] dx, dz;
	logic [DW-1:0]        ax_s2, az_s2;
	logic [WEIGHT_W-1:0]  w_rd, w_s2;
	logic [SQW-1:0]       px_s3, pz_s3;
	logic [W2W-1:0]       w2_s3, w2_s4;
	logic [SW-1:0]        s_s4;

	assign dx   = {qx_q[C-1], qx_q} - $signed({ram_rdata[C-1], ram_rdata[C-1:0]});
	assign dz   = {qz_q[C-1], qz_q} - $signed({ram_rdata[2*C-1], ram_rdata[2*C-1:C]});
	assign w_rd = ram_rdata[EW-1:2*C];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.rd_first;
		last_s1  <= cmd.rd_last;
		idx_s1   <= AW'(cmd.rd_addr);

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		idx_s2   <= idx_s1;
		ax_s2    <= dx[DW-1] ? DW'(-dx) : DW'(dx);
		az_s2    <= dz[DW-1] ? DW'(-dz) : DW'(dz);
		w_s2     <= (w_rd == '0) ? WEIGHT_W'(1) : w_rd;

		first_s3 <= first_s2;
		last_s3  <= last_s2;
		idx_s3   <= idx_s2;
		px_s3    <= SQW'(ax_s2) * SQW'(ax_s2);
		pz_s3    <= SQW'(az_s2) * SQW'(az_s2);
		w2_s3    <= W2W'(w_s2) * W2W'(w_s2);

		first_s4 <= first_s3;
		last_s4  <= last_s3;
		idx_s4   <= idx_s3;
		s_s4     <= SW'(px_s3) + SW'(pz_s3);
		w2_s4    <= w2_s3;
	end

	// Running best and second-best seed, ties kept by the earlier entry.
	logic [AW-1:0]  best_q, second_q;
	logic [SW-1:0]  sb_q, ss_q;
	logic [W2W-1:0] wb2_q, ws2_q;
	logic           have_second_q;
	logic [PW-1:0]  p_ib, p_bi, p_is, p_si;
	logic           lt_best, lt_second;

	assign p_ib      = PW'(s_s4) * PW'(wb2_q);
	assign p_bi      = PW'(sb_q) * PW'(w2_s4);
	assign p_is      = PW'(s_s4) * PW'(ws2_q);
	assign p_si      = PW'(ss_q) * PW'(w2_s4);
	assign lt_best   = p_ib < p_bi;
	assign lt_second = p_is < p_si;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_second_q <= 1'b0;
		end else if (valid_s4) begin
			have_second_q <= !first_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			if (first_s4) begin
				best_q <= idx_s4;
				sb_q   <= s_s4;
				wb2_q  <= w2_s4;
			end else if (lt_best) begin
				second_q <= best_q;
				ss_q     <= sb_q;
				ws2_q    <= wb2_q;
				best_q   <= idx_s4;
				sb_q     <= s_s4;
				wb2_q    <= w2_s4;
			end else if (!have_second_q || lt_second) begin
				second_q <= idx_s4;
				ss_q     <= s_s4;
				ws2_q    <= w2_s4;
			end
		end
	end

	// Border test operands.
	logic [PW-1:0] lhs_q, rhs_q;
	logic [LW-1:0] lhs_k, rhs_k;
	logic          near_border, loud, switch_sel;

	always_ff @(posedge clk) begin
		if (cmd.border) begin
			lhs_q <= PW'(sb_q) * PW'(ws2_q);
			rhs_q <= PW'(ss_q) * PW'(wb2_q);
		end
	end

	assign lhs_k       = LW'(lhs_q) * LW'(BORDER_NEAR_K);
	assign rhs_k       = LW'(rhs_q) * LW'(BORDER_FAR_K);
	assign near_border = lhs_k > rhs_k;
	assign loud        = noise_q > thr_q;
	assign switch_sel  = !empty_q && have_second_q && near_border && loud;

	// Output register.
	logic                m_tvalid_q;
	logic [REGION_W-1:0] region_q;
	logic                switched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			switched_q <= switch_sel;
			if (empty_q) begin
				region_q <= '0;
			end else if (switch_sel) begin
				region_q <= REGION_W'(second_q) + REGION_W'(1);
			end else begin
				region_q <= REGION_W'(best_q) + REGION_W'(1);
			end
		end
	end

	assign m_tvalid        = m_tvalid_q;
	assign region_id       = region_q;
	assign border_switched = switched_q;

	assign sts.scan_done = valid_s4 && last_s4;
	assign sts.out_free  = !m_tvalid_q || m_tready;
	assign sts.count     = count_eff;

endmodule
